// File: rtl/mono_framebuffer_raster_engine_top_defines.svh
// Assertion macros for the frame buffer raster engine.
// Included by the modules that carry assertions; no other dependencies.
`ifndef MONO_FRAMEBUFFER_RASTER_ENGINE_TOP_DEFINES_SVH
`define MONO_FRAMEBUFFER_RASTER_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MFR_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MFR_ASSERT(lbl, clk, rst_n, prop, msg)
`define MFR_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/mfr_pkg.sv
// Shared types and constants for the frame buffer raster engine.
// No dependencies.
package mfr_pkg;
    localparam int COLUMNS    = 128;
    localparam int PAGES      = 8;
    localparam int ROWS       = PAGES * 8;
    localparam int STORE_SIZE = COLUMNS * PAGES;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int PG_W       = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW         = 11;   // signed coordinate width
    localparam int EW         = 20;   // circle term width

    typedef enum logic [2:0] {
        OP_SET = 3'd0, OP_CLR = 3'd1, OP_LINE = 3'd2,
        OP_RECT = 3'd3, OP_CIRC = 3'd4, OP_READ = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_LSETUP, ST_LPLOT,
        ST_RD, ST_WR, ST_CSETUP, ST_CTEST, ST_CPT, ST_CSTEP, ST_RDBYTE, ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_step;     // write zero at clear counter, advance
        logic lat_cmd;      // capture command
        logic line_setup;   // load line endpoints for current segment
        logic line_step;    // advance DDA
        logic pix_line;     // 1: pixel from line, 0: from circle/point
        logic pix_point;    // pixel is the command point
        logic pix_load;     // latch pixel coordinate
        logic mem_rd;       // read byte at pixel address
        logic mem_wr;       // write modified byte
        logic pix_on;
        logic circ_setup;
        logic circ_test;    // register 2b*b - r*r sign
        logic circ_step;
        logic rd_byte;      // read byte for read command
        logic rd_lat;       // capture read data as result
        logic seg_next;
        logic clr_result;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic line_last;
        logic seg_last;
        logic circ_run;
        logic pix_valid;
        logic r_zero;
    } t_sts;
endpackage

// File: rtl/mfr_datapath.sv
// Datapath: frame store, DDA line stepper, circle stepper, pixel RMW.
// Depends on mfr_pkg and the defines header.
`include "mono_framebuffer_raster_engine_top_defines.svh"
module mfr_datapath import mfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctl       i_ctl,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_start_x,
    input  logic [7:0] i_start_y,
    input  logic [7:0] i_end_x,
    input  logic [7:0] i_end_y,
    input  logic [7:0] i_radius,
    input  logic [2:0] i_page,
    input  logic [2:0] i_pt_idx,
    output t_sts       o_sts,
    output logic [2:0] o_op,
    output logic [7:0] o_result
);
    logic [7:0] mem [STORE_SIZE];
    logic [ADDR_W:0] r_clr_cnt;
    logic [7:0] r_rdata;

    logic [2:0] r_op;
    logic [7:0] r_x1, r_y1, r_x2, r_y2, r_r;
    logic [2:0] r_pg;
    logic [1:0] r_seg;

    // line state
    logic signed [CW-1:0] r_cx, r_cy;
    logic [8:0] r_dx, r_dy, r_dist, r_ex, r_ey, r_t;
    logic r_sxn, r_syn, r_sxz, r_syz;

    // circle state
    logic signed [CW-1:0] r_a, r_b;
    logic signed [EW-1:0] r_rr, r_cterm;
    logic r_run;

    // pixel
    logic signed [CW-1:0] r_px, r_py;
    logic [7:0] r_result;

    assign o_op     = r_op;
    assign o_result = r_result;

    // segment endpoints for the rectangle's four sides
    logic [7:0] s_x1, s_y1, s_x2, s_y2;
    always_comb begin
        s_x1 = r_x1; s_y1 = r_y1; s_x2 = r_x2; s_y2 = r_y2;
        if (r_op == OP_RECT) begin
            unique case (r_seg)
                2'd0: begin s_x2 = r_x1; end
                2'd1: begin s_y2 = r_y1; end
                2'd2: begin s_y1 = r_y2; end
                default: begin s_x1 = r_x2; end
            endcase
        end
    end

    // circle symmetric point
    logic signed [CW-1:0] c_px, c_py, cen_x, cen_y;
    always_comb begin
        cen_x = CW'($signed({1'b0, r_x1}));
        cen_y = CW'($signed({1'b0, r_y1}));
        unique case (i_pt_idx)
            3'd0: begin c_px = cen_x + r_a; c_py = cen_y - r_b; end
            3'd1: begin c_px = cen_x - r_a; c_py = cen_y - r_b; end
            3'd2: begin c_px = cen_x - r_a; c_py = cen_y + r_b; end
            3'd3: begin c_px = cen_x + r_a; c_py = cen_y + r_b; end
            3'd4: begin c_px = cen_x + r_b; c_py = cen_y + r_a; end
            3'd5: begin c_px = cen_x + r_b; c_py = cen_y - r_a; end
            3'd6: begin c_px = cen_x - r_b; c_py = cen_y - r_a; end
            default: begin c_px = cen_x - r_b; c_py = cen_y + r_a; end
        endcase
    end

    logic pix_ok;
    assign pix_ok = (r_px >= 0) && (r_py >= 0) && (r_px < CW'(COLUMNS)) && (r_py < CW'(ROWS));
    logic [ADDR_W-1:0] pix_addr;
    assign pix_addr = ADDR_W'(r_px[ADDR_W-1:0] * PAGES + ADDR_W'(r_py >>> 3));
    logic [7:0] pix_mask;
    assign pix_mask = 8'(1) << r_py[2:0];

    logic [ADDR_W-1:0] rd_addr;
    assign rd_addr = ADDR_W'(ADDR_W'(r_x1) * PAGES + ADDR_W'(r_pg));

    // line deltas from current segment
    logic [8:0] l_dx, l_dy;
    assign l_dx = (s_x2 >= s_x1) ? 9'(s_x2 - s_x1) : 9'(s_x1 - s_x2);
    assign l_dy = (s_y2 >= s_y1) ? 9'(s_y2 - s_y1) : 9'(s_y1 - s_y2);

    logic [9:0] n_ex, n_ey;
    assign n_ex = 10'(r_ex) + 10'(r_dx);
    assign n_ey = 10'(r_ey) + 10'(r_dy);

    // frame store: clear sweep, read and write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_step) mem[r_clr_cnt[ADDR_W-1:0]] <= 8'd0;
        else if (i_ctl.mem_wr)
            mem[pix_addr] <= i_ctl.pix_on ? (r_rdata | pix_mask) : (r_rdata & ~pix_mask);
        if (i_ctl.mem_rd) r_rdata <= mem[pix_addr];
        else if (i_ctl.rd_byte) r_rdata <= mem[rd_addr];
    end

    // advance clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_cnt <= '0;
        else if (i_ctl.clr_step) r_clr_cnt <= r_clr_cnt + 1'b1;
    end

    // hold command and drawing state
    always_ff @(posedge i_clk) begin
        if (i_ctl.lat_cmd) begin
            r_op <= i_opcode; r_x1 <= i_start_x; r_y1 <= i_start_y;
            r_x2 <= i_end_x; r_y2 <= i_end_y; r_r <= i_radius; r_pg <= i_page;
            r_seg <= 2'd0;
        end else if (i_ctl.seg_next) r_seg <= r_seg + 2'd1;
        if (i_ctl.clr_result) r_result <= 8'd0;
        else if (i_ctl.rd_lat)
            r_result <= (r_x1 < 8'(COLUMNS) || COLUMNS > 255) && (32'(r_pg) < PAGES)
                ? r_rdata : 8'd0;
        if (i_ctl.line_setup) begin
            r_cx <= CW'(s_x1); r_cy <= CW'(s_y1);
            r_dx <= l_dx; r_dy <= l_dy;
            r_dist <= (l_dx > l_dy) ? l_dx : l_dy;
            r_sxn <= s_x2 < s_x1; r_syn <= s_y2 < s_y1;
            r_sxz <= s_x2 == s_x1; r_syz <= s_y2 == s_y1;
            r_ex <= '0; r_ey <= '0; r_t <= '0;
        end else if (i_ctl.line_step) begin
            r_t <= r_t + 9'd1;
            if (n_ex > 10'(r_dist)) begin
                r_ex <= 9'(n_ex - 10'(r_dist));
                if (!r_sxz) r_cx <= r_sxn ? r_cx - 1'b1 : r_cx + 1'b1;
            end else r_ex <= n_ex[8:0];
            if (n_ey > 10'(r_dist)) begin
                r_ey <= 9'(n_ey - 10'(r_dist));
                if (!r_syz) r_cy <= r_syn ? r_cy - 1'b1 : r_cy + 1'b1;
            end else r_ey <= n_ey[8:0];
        end
        if (i_ctl.pix_load) begin
            if (i_ctl.pix_point) begin
                r_px <= CW'(r_x1); r_py <= CW'(r_y1);
            end else if (i_ctl.pix_line) begin
                r_px <= r_cx; r_py <= r_cy;
            end else begin
                r_px <= c_px; r_py <= c_py;
            end
        end
    end

    // circle stepper; cterm tracks a*a + b*b - r*r, test uses 2b*b - r*r
    logic signed [EW-1:0] bb2, a1_term;
    assign bb2     = (EW'(r_b) * EW'(r_b)) <<< 1;
    assign a1_term = r_cterm + EW'(r_a <<< 1) + EW'(1);
    always_ff @(posedge i_clk) begin
        if (i_ctl.circ_setup) begin
            r_a <= '0; r_b <= CW'(r_r);
            r_rr <= EW'(EW'(r_r) * EW'(r_r));
            r_cterm <= '0;
        end else if (i_ctl.circ_test) begin
            r_run <= (bb2 - r_rr) >= 0;
        end else if (i_ctl.circ_step) begin
            // a++, then if term>0: b--, a--
            if (a1_term > 0) begin
                r_b <= r_b - 1'b1;
                r_cterm <= r_cterm - EW'(r_b <<< 1) + EW'(1);
            end else begin
                r_a <= r_a + 1'b1;
                r_cterm <= a1_term;
            end
        end
    end

    assign o_sts.clr_done   = r_clr_cnt == (ADDR_W+1)'(STORE_SIZE);
    assign o_sts.line_last  = r_t == r_dist;
    assign o_sts.seg_last   = (r_op != OP_RECT) || (r_seg == 2'd3);
    assign o_sts.circ_run   = r_run;
    assign o_sts.pix_valid  = pix_ok;
    assign o_sts.r_zero     = r_r == 8'd0;

    `MFR_ASSERT(a_no_wr_clear, i_clk, i_rst_n, !(i_ctl.clr_step && i_ctl.mem_wr),
        "write during clear sweep")
    `MFR_ASSERT(a_wr_in_range, i_clk, i_rst_n, i_ctl.mem_wr |-> pix_ok,
        "write to off-screen pixel")
    `MFR_ASSERT(a_wr_after_rd, i_clk, i_rst_n, i_ctl.mem_wr |-> $past(i_ctl.mem_rd),
        "write without preceding read")
endmodule

// File: rtl/mfr_ctrl.sv
// Controller state machine for the raster engine.
// Depends on mfr_pkg and the defines header.
`include "mono_framebuffer_raster_engine_top_defines.svh"
module mfr_ctrl import mfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_in_ready,
    output logic       o_valid,
    input  logic       i_out_ready,
    input  t_sts       i_sts,
    input  logic [2:0] i_op,
    output t_ctl       o_ctl,
    output logic [2:0] o_pt_idx
);
    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic [2:0] r_pt, n_pt;
    logic r_out_v, n_out_v;

    assign o_pt_idx   = r_pt;
    assign o_valid    = r_out_v;
    assign o_in_ready = (r_state == ST_IDLE) && !r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR; r_ret <= ST_IDLE; r_pt <= '0; r_out_v <= 1'b0;
        end else begin
            r_state <= n_state; r_ret <= n_ret; r_pt <= n_pt; r_out_v <= n_out_v;
        end
    end

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_pt = r_pt;
        n_out_v = r_out_v && !i_out_ready;
        o_ctl = '0;
        o_ctl.pix_on = (i_op != OP_CLR);
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) n_state = ST_IDLE;
                else o_ctl.clr_step = 1'b1;
            end
            ST_IDLE: begin
                if (i_valid && o_in_ready) begin
                    o_ctl.lat_cmd = 1'b1;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                o_ctl.clr_result = 1'b1;
                priority if (i_op == OP_SET || i_op == OP_CLR) begin
                    o_ctl.pix_load = 1'b1; o_ctl.pix_point = 1'b1;
                    n_ret = ST_OUT; n_state = ST_RD;
                end else if (i_op == OP_LINE || i_op == OP_RECT) begin
                    n_state = ST_LSETUP;
                end else if (i_op == OP_CIRC) begin
                    if (i_sts.r_zero) begin
                        o_ctl.pix_load = 1'b1; o_ctl.pix_point = 1'b1;
                        n_ret = ST_OUT; n_state = ST_RD;
                    end else n_state = ST_CSETUP;
                end else if (i_op == OP_READ) begin
                    n_state = ST_RDBYTE;
                end else n_state = ST_OUT;
            end
            ST_LSETUP: begin
                o_ctl.line_setup = 1'b1;
                n_state = ST_LPLOT;
            end
            ST_LPLOT: begin
                // plot current point then step
                o_ctl.pix_load = 1'b1; o_ctl.pix_line = 1'b1;
                o_ctl.line_step = 1'b1;
                n_state = ST_RD;
                if (!i_sts.line_last) n_ret = ST_LPLOT;
                else if (!i_sts.seg_last) begin
                    n_ret = ST_LSETUP; o_ctl.seg_next = 1'b1;
                end else n_ret = ST_OUT;
            end
            ST_RD: begin
                if (i_sts.pix_valid) begin
                    o_ctl.mem_rd = 1'b1; n_state = ST_WR;
                end else n_state = r_ret;
            end
            ST_WR: begin
                o_ctl.mem_wr = 1'b1;
                n_state = r_ret;
            end
            ST_CSETUP: begin
                o_ctl.circ_setup = 1'b1;
                n_state = ST_CTEST;
            end
            ST_CTEST: begin
                o_ctl.circ_test = 1'b1;
                n_state = ST_CPT; n_pt = '0;
            end
            ST_CPT: begin
                if (!i_sts.circ_run) n_state = ST_OUT;
                else begin
                    o_ctl.pix_load = 1'b1;
                    n_state = ST_RD;
                    n_pt = r_pt + 3'd1;
                    n_ret = (r_pt == 3'd7) ? ST_CSTEP : ST_CPT;
                end
            end
            ST_CSTEP: begin
                o_ctl.circ_step = 1'b1;
                n_state = ST_CTEST;
            end
            ST_RDBYTE: begin
                // fetch the addressed byte; mark the return so the result is taken
                o_ctl.rd_byte = 1'b1;
                n_state = ST_OUT;
                n_ret = ST_RDBYTE;
            end
            ST_OUT: begin
                if (r_ret == ST_RDBYTE && i_op == OP_READ) o_ctl.rd_lat = 1'b1;
                n_out_v = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `MFR_ASSERT(a_out_hold, i_clk, i_rst_n, (r_out_v && !i_out_ready) |=> r_out_v,
        "result dropped while stalled")
    `MFR_ASSERT(a_no_acc_busy, i_clk, i_rst_n, o_in_ready |-> (r_state == ST_IDLE),
        "input accepted while busy")
    `MFR_ASSERT(a_wr_ret, i_clk, i_rst_n, o_ctl.mem_wr |-> (r_state == ST_WR),
        "store write outside write step")
endmodule

// File: rtl/mono_framebuffer_raster_engine_top.sv
// Top level of the monochrome frame buffer raster engine.
// Depends on mfr_pkg, mfr_ctrl and mfr_datapath.
//
// Input channel: i_valid/o_ready with opcode, start/end coordinates,
// radius and page. Output channel: o_valid/i_ready with o_read_byte,
// exactly one result per command (zero for drawing commands).
// After reset the store is swept to zero, one byte a cycle, with o_ready
// low. One command is processed at a time. Every plotted pixel is a
// read-modify-write of the frame store: an on-screen pixel passes ST_RD
// and ST_WR, an off-screen pixel is skipped at ST_RD with no write. A line
// plots its span+1 pixels, a rectangle its four sides, a circle eight
// points per step. Worst case is a radius-255 circle. The result sits in
// an output register; a new command is taken the cycle after it has been
// delivered, so a stalled receiver holds the engine idle without losing
// anything.
module mono_framebuffer_raster_engine_top import mfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_start_x,
    input  logic [7:0] i_start_y,
    input  logic [7:0] i_end_x,
    input  logic [7:0] i_end_y,
    input  logic [7:0] i_radius,
    input  logic [2:0] i_page,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_byte
);
    t_ctl ctl;
    t_sts sts;
    logic [2:0] op, pt_idx;

    mfr_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_in_ready(o_ready), .o_valid,
        .i_out_ready(i_ready), .i_sts(sts), .i_op(op), .o_ctl(ctl), .o_pt_idx(pt_idx)
    );

    mfr_datapath u_dp (
        .i_clk, .i_rst_n, .i_ctl(ctl), .i_opcode, .i_start_x, .i_start_y,
        .i_end_x, .i_end_y, .i_radius, .i_page, .i_pt_idx(pt_idx),
        .o_sts(sts), .o_op(op), .o_result(o_read_byte)
    );
endmodule
